// ----- src/lru_key_value_cache_core_macros.svh -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_macros
// Assertion macros for the LRU key/value cache.
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define LKV_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lkv assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define LKV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lkv assertion failed");

`endif

// ----- src/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;
	localparam int CAP_W         = 5;
	localparam int APB_DATA_W    = 32;
	localparam int PADDR_W       = 3;
	localparam int REG_IDX_W     = PADDR_W - 2;

	localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);
	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// One request as held in the input stage
	typedef struct packed {
		op_t   op;
		data_t key;
		data_t write_value;
	} req_t;

	// One result as held in the output stage
	typedef struct packed {
		logic  hit;
		data_t read_value;
	} rsp_t;

endpackage

// ----- src/lkv_if.sv -----
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// Valid/ready channels for cache requests and cache results.
// ----------------------------------------------------------------------------
interface lkv_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] key;
	logic signed [31:0] write_value;

	modport source (output valid, output op, output key, output write_value, input ready);
	modport sink   (input valid, input op, input key, input write_value, output ready);
endinterface

interface lkv_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ----- src/lru_key_value_cache_core.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative LRU key/value cache.
// Requests pass through the input register and then the result register, which holds
// each result until taken. One request per cycle while the result channel is not stalled;
// the whole entry array is compared in the input stage.
// Reset invalidates all entries, clears ranks and the fill count; capacity returns to 16.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_macros.svh"

module lru_key_value_cache_core
	import lkv_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lkv_req_if.sink               req,
	lkv_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic             v_s1;
	req_t             req_s1;
	logic             v_s2;
	rsp_t             rsp_s2;
	logic             adv;
	rsp_t             lookup;
	logic [CAP_W-1:0] capacity;

	lkv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	lkv_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (adv),
		.req      (req_s1),
		.capacity (capacity),
		.rsp      (lookup)
	);

	// Advance the input stage when the result register is free or drains
	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Capture the request transaction
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.op          <= op_t'(req.op);
			req_s1.key         <= req.key;
			req_s1.write_value <= req.write_value;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (rsp.ready) begin
			v_s2 <= 1'b0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= lookup;
		end
	end

	assign rsp.valid      = v_s2;
	assign rsp.hit        = rsp_s2.hit;
	assign rsp.read_value = rsp_s2.read_value;

	// A put never returns data, and a miss returns zero
	`LKV_ASSERT_SAME(a_put_no_data, adv && (req_s1.op == OP_PUT || !lookup.hit), lookup.read_value == '0)
	// A request leaving the input stage always lands in the result register
	`LKV_ASSERT_NEXT(a_adv_loads_s2, adv, v_s2)
	// A stalled request stays in the input stage
	`LKV_ASSERT_NEXT(a_s1_held, v_s1 && !adv, v_s1 && $stable(req_s1))

endmodule

// ----- src/lkv_cfg.sv -----
// ----------------------------------------------------------------------------
// lkv_cfg
// APB register file holding the capacity register.
// ----------------------------------------------------------------------------
module lkv_cfg
	import lkv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [CAP_W-1:0]      capacity
);

	logic [CAP_W-1:0]     cap_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	// Decode the register index from the word address
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en && reg_idx == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Return the register value on reads
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_CAPACITY: prdata = APB_DATA_W'(cap_q);
			default:      prdata = '0;
		endcase
	end

	assign capacity = cap_q;

endmodule

// ----- src/lkv_store.sv -----
// ----------------------------------------------------------------------------
// lkv_store
// Entry array with parallel key compare, recency ranks and LRU replacement.
// ----------------------------------------------------------------------------
module lkv_store
	import lkv_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	output rsp_t             rsp
);

	localparam int RW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	data_t            keys_q [DEPTH];
	data_t            vals_q [DEPTH];
	logic [RW-1:0]    rank_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CW-1:0]    count_q;

	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] victim;
	logic [DEPTH-1:0] free_vec;
	logic [DEPTH-1:0] free_oh;
	logic [DEPTH-1:0] tgt;
	logic             hit;
	logic             is_put;
	logic             full;
	logic             fill;
	logic             touch;
	data_t            rd_value;
	logic [RW-1:0]    hit_rank;
	logic [CW-1:0]    old_rank;
	logic [CW-1:0]    lru_rank;
	logic [CAP_W-1:0] cap_eff;

	// Compare the key against every entry; read value and rank of the match
	always_comb begin
		rd_value = '0;
		hit_rank = '0;
		lru_rank = count_q - CW'(1);
		for (int i = 0; i < DEPTH; i++) begin
			match[i]  = valid_q[i] && (keys_q[i] == req.key);
			victim[i] = valid_q[i] && (CW'(rank_q[i]) == lru_rank);
			if (match[i]) begin
				rd_value = rd_value | vals_q[i];
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	// Pick the lowest free entry
	assign free_vec = ~valid_q;
	assign free_oh  = free_vec & (~free_vec + DEPTH'(1));

	// Decide hit, fill or eviction
	assign hit     = |match;
	assign is_put  = (req.op == OP_PUT);
	assign cap_eff = (capacity == '0) ? CAP_W'(1) : capacity;
	assign full    = (count_q >= CW'(DEPTH)) || (CMPW'(count_q) >= CMPW'(cap_eff));
	assign fill    = is_put && !hit && !full;
	assign touch   = hit || is_put;

	always_comb begin
		if (hit) begin
			tgt      = match;
			old_rank = CW'(hit_rank);
		end else if (full) begin
			tgt      = victim;
			old_rank = lru_rank;
		end else begin
			tgt      = free_oh;
			old_rank = count_q;
		end
	end

	// Update valid bits, ranks and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				rank_q[i] <= '0;
			end
		end else if (upd && touch) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (tgt[i]) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (CW'(rank_q[i]) < old_rank)) begin
					rank_q[i] <= rank_q[i] + RW'(1);
				end
			end
			if (fill) begin
				valid_q <= valid_q | tgt;
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Write key and value of a put into the target entry
	always_ff @(posedge clk) begin
		if (upd && is_put) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (tgt[i]) begin
					keys_q[i] <= req.key;
					vals_q[i] <= req.write_value;
				end
			end
		end
	end

	assign rsp.hit        = hit;
	assign rsp.read_value = (hit && !is_put) ? rd_value : '0;

endmodule

// ----- verif/lru_key_value_cache_core_tb.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_tb
// Drives get/put requests into the LRU key/value cache and checks each result
// against a local model of the entry array, the recency order and the fill
// count. Capacity is changed over the APB port between phases, including the
// zero and over-depth settings and a cut below the current fill count.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core_tb;
	import lkv_pkg::*;

	localparam int                 SLOTS         = DEPTH_DEFAULT;
	localparam int                 PHASE_ITEMS   = 250;
	localparam int                 KEY_POOL_MAX  = 24;
	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'({REG_CAPACITY, 2'b00});

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lkv_req_if req ();
	lkv_rsp_if rsp ();

	lru_key_value_cache_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the cache contents
	data_t            slot_key   [SLOTS];
	data_t            slot_value [SLOTS];
	bit               slot_valid [SLOTS];
	int               slot_rank  [SLOTS];
	int               fill_count;
	logic [CAP_W-1:0] capacity_reg;

	rsp_t  pending_lookups[$];
	int    error_count;
	bit    sender_idles;
	bit    receiver_stalls;
	int    stall_left;
	data_t key_pool[KEY_POOL_MAX];
	int    key_pool_size;

	// Move one entry to the front; entries that were more recent shift back by one
	function automatic void promote_entry(int idx);
		int old_rank;
		old_rank = slot_rank[idx];
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_valid[i] && i != idx && slot_rank[i] < old_rank)
				slot_rank[i]++;
		end
		slot_rank[idx] = 0;
	endfunction

	function automatic int usable_capacity();
		if (capacity_reg < 1)
			return 1;
		if (capacity_reg > SLOTS)
			return SLOTS;
		return int'(capacity_reg);
	endfunction

	// Apply one request to the local cache and return the result it must give
	function automatic rsp_t lookup_and_update(op_t op, data_t key, data_t value);
		rsp_t result;
		int   found;
		int   slot;
		int   worst;
		found = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_valid[i] && slot_key[i] == key) begin
				found = i;
				break;
			end
		end
		result.hit        = (found >= 0);
		result.read_value = '0;
		if (op == OP_GET) begin
			if (found >= 0) begin
				result.read_value = slot_value[found];
				promote_entry(found);
			end
			return result;
		end
		if (found >= 0) begin
			slot_value[found] = value;
			promote_entry(found);
			return result;
		end
		slot = -1;
		if (fill_count >= usable_capacity()) begin
			// Full: overwrite the least recent entry, count unchanged
			worst = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_valid[i] && (slot < 0 || slot_rank[i] > worst)) begin
					slot  = i;
					worst = slot_rank[i];
				end
			end
			if (slot >= 0) begin
				slot_key[slot]   = key;
				slot_value[slot] = value;
				promote_entry(slot);
			end
		end else begin
			// Room left: take the lowest free entry, entering behind all others
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_valid[i]) begin
					slot = i;
					break;
				end
			end
			if (slot >= 0) begin
				slot_rank[slot]  = fill_count;
				slot_valid[slot] = 1'b1;
				slot_key[slot]   = key;
				slot_value[slot] = value;
				fill_count++;
				promote_entry(slot);
			end
		end
		return result;
	endfunction

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Check each result transaction, then record each request transaction
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (pending_lookups.size() == 0) begin
					$error("unexpected result: hit=%0b read_value=%0d", rsp.hit, rsp.read_value);
					error_count++;
				end else begin
					want = pending_lookups.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, rsp.hit);
						error_count++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							want.read_value, rsp.read_value);
						error_count++;
					end
				end
			end
			if (req.valid && req.ready)
				pending_lookups.push_back(lookup_and_update(op_t'(req.op), req.key,
					req.write_value));
		end
	end

	// Hold off the result channel at random
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
			rsp.ready <= 1'b0;
			stall_left = idle_length() - 1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Send one request; valid stays high into the next call when there is no gap
	task automatic send_request(op_t op, data_t key, data_t value);
		int gap;
		gap = 0;
		if (sender_idles && $urandom_range(0, 99) < 35)
			gap = idle_length();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.op          <= op;
		req.key         <= key;
		req.write_value <= value;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	// Drop valid and wait until every result is back and the pipeline is empty
	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_transfer(bit is_write, logic [PADDR_W-1:0] addr,
			logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the capacity while idle, mirror it and read it back
	task automatic set_capacity(logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] readback;
		wait_idle();
		apb_transfer(1'b1, CAPACITY_ADDR, value, readback);
		capacity_reg = value[CAP_W-1:0];
		// Return to idle between the two transfers
		@(posedge clk);
		apb_transfer(1'b0, CAPACITY_ADDR, '0, readback);
		if (readback !== APB_DATA_W'(capacity_reg)) begin
			$error("capacity: expected %0d, actual %0d", capacity_reg, readback);
			error_count++;
		end
	endtask

	// Empty store, field extremes, overwrite of a present key, misses
	task automatic test_basic_access();
		send_request(OP_GET, data_t'(0), data_t'($urandom));
		send_request(OP_PUT, data_t'(32'h8000_0000), data_t'(32'h7FFF_FFFF));
		send_request(OP_PUT, data_t'(32'h7FFF_FFFF), data_t'(32'h8000_0000));
		send_request(OP_PUT, data_t'(-1), data_t'(-1));
		send_request(OP_GET, data_t'(-1), data_t'(0));
		send_request(OP_PUT, data_t'(0), data_t'(0));
		send_request(OP_GET, data_t'(32'h8000_0000), data_t'(-1));
		send_request(OP_PUT, data_t'(-1), data_t'(5));
		send_request(OP_GET, data_t'(-1), data_t'($urandom));
		send_request(OP_GET, data_t'(12345), data_t'($urandom));
	endtask

	// Capacity cut below the fill count, zero, and above the depth
	task automatic test_capacity_limits();
		set_capacity(2);
		send_request(OP_PUT, data_t'(100), data_t'(1000));
		send_request(OP_PUT, data_t'(101), data_t'(1001));
		send_request(OP_GET, data_t'(32'h7FFF_FFFF), data_t'(0));
		send_request(OP_GET, data_t'(32'h8000_0000), data_t'(0));
		set_capacity(0);
		send_request(OP_PUT, data_t'(200), data_t'(2000));
		send_request(OP_PUT, data_t'(201), data_t'(2001));
		send_request(OP_GET, data_t'(200), data_t'(0));
		send_request(OP_GET, data_t'(201), data_t'(0));
		set_capacity(31);
		send_request(OP_PUT, data_t'(300), data_t'(3000));
		send_request(OP_PUT, data_t'(301), data_t'(3001));
		send_request(OP_GET, data_t'(300), data_t'(0));
	endtask

	// Random gets and puts over a small key set sized to the capacity,
	// with some fully random keys mixed in
	task automatic test_random_traffic();
		logic [APB_DATA_W-1:0] phase_capacity[7];
		data_t                 key;
		op_t                   op;
		phase_capacity = '{16, 1, 31, 0, 7, 3, 0};
		phase_capacity[6] = $urandom_range(0, 31);
		for (int phase = 0; phase < 7; phase++) begin
			set_capacity(phase_capacity[phase]);
			sender_idles    = (phase % 3 != 0);
			receiver_stalls = (phase % 3 != 1);
			key_pool_size   = usable_capacity() + $urandom_range(1, 6);
			if (key_pool_size > KEY_POOL_MAX)
				key_pool_size = KEY_POOL_MAX;
			for (int i = 0; i < KEY_POOL_MAX; i++)
				key_pool[i] = data_t'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 85)
					key = key_pool[$urandom_range(0, key_pool_size - 1)];
				else
					key = data_t'($urandom);
				op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
				send_request(op, key, data_t'($urandom));
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		req.valid       = 1'b0;
		req.op          = OP_GET;
		req.key         = '0;
		req.write_value = '0;
		rsp.ready       = 1'b0;
		error_count     = 0;
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_valid[i] = 1'b0;
			slot_rank[i]  = 0;
		end
		fill_count   = 0;
		capacity_reg = CAP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_access();
		test_capacity_limits();
		test_random_traffic();

		// Drain, with a bound on how long results may take
		req.valid <= 1'b0;
		for (int n = 0; n < 2000 && pending_lookups.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			$error("results missing: %0d requests never answered", pending_lookups.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/lkv_pkg.sv
src/lkv_if.sv
src/lkv_cfg.sv
src/lkv_store.sv
src/lru_key_value_cache_core.sv
verif/lru_key_value_cache_core_tb.sv
